FILE: sv/dnh_pkg.sv
package dnh_pkg;

	localparam int WordW = 32;
	localparam int NumChain = 4;
	localparam int NumBlockWords = 8;
	localparam int StepW = 5;

	localparam logic [WordW-1:0] MD4_K2 = 32'h5a827999;
	localparam logic [WordW-1:0] MD4_K3 = 32'h6ed9eba1;
	localparam logic [NumChain-1:0][WordW-1:0] MD4_START =
		{32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};
	localparam logic [WordW-1:0] HASH_SPECIAL = 32'hfffffffe;
	localparam logic [WordW-1:0] HASH_SUBST = 32'hfffffffc;

	localparam logic [7:0] VER_SIGNED = 8'd1;
	localparam logic [7:0] VER_UNSIGNED = 8'd4;

	localparam logic [2:0] REG_SEED0 = 3'd0;
	localparam logic [2:0] REG_SEED1 = 3'd1;
	localparam logic [2:0] REG_SEED2 = 3'd2;
	localparam logic [2:0] REG_SEED3 = 3'd3;
	localparam logic [2:0] REG_VERSION = 3'd4;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_BAD_VERSION = 1'b1;

	// Micro-operations.
	localparam logic [1:0] OP_NOP = 2'd0;
	localparam logic [1:0] OP_ROUND = 2'd1;
	localparam logic [1:0] OP_FOLD = 2'd2;
	localparam logic [1:0] OP_EMIT = 2'd3;

	// Round functions.
	localparam logic [1:0] FN_F = 2'd0;
	localparam logic [1:0] FN_G = 2'd1;
	localparam logic [1:0] FN_H = 2'd2;

	// Sequencing.
	localparam logic [1:0] SEQ_NEXT = 2'd0;
	localparam logic [1:0] SEQ_JLAST = 2'd1;
	localparam logic [1:0] SEQ_WAIT = 2'd2;
	localparam logic [1:0] SEQ_STOP = 2'd3;

	localparam logic [StepW-1:0] STEP_FIRST = 5'd0;
	localparam logic [StepW-1:0] STEP_FOLD = 5'd24;
	localparam logic [StepW-1:0] STEP_EMIT = 5'd25;

	typedef struct packed {
		logic [7:0] name_byte;
		logic [7:0] total_len;
		logic       last_byte;
	} byte_req_t;

	typedef struct packed {
		logic [31:0] hash_value;
		logic        status;
	} hash_rsp_t;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] fsel;
		logic [2:0] widx;
		logic [4:0] rot;
		logic [1:0] seq;
	} ctrl_t;

	typedef struct packed {
		logic go_xform;
		logic go_emit;
		logic is_last;
	} launch_t;

	function automatic ctrl_t ucode_rom(input logic [StepW-1:0] addr);
		logic [7:0][2:0] ord_g;
		logic [7:0][2:0] ord_h;
		logic [3:0][4:0] sh_f;
		logic [3:0][4:0] sh_g;
		logic [3:0][4:0] sh_h;
		ctrl_t cw;
		ord_g = {3'd6, 3'd4, 3'd2, 3'd0, 3'd7, 3'd5, 3'd3, 3'd1};
		ord_h = {3'd4, 3'd0, 3'd5, 3'd1, 3'd6, 3'd2, 3'd7, 3'd3};
		sh_f = {5'd19, 5'd11, 5'd7, 5'd3};
		sh_g = {5'd13, 5'd9, 5'd5, 5'd3};
		sh_h = {5'd15, 5'd11, 5'd9, 5'd3};
		cw.op = OP_NOP;
		cw.fsel = FN_F;
		cw.widx = addr[2:0];
		cw.rot = sh_f[addr[1:0]];
		cw.seq = SEQ_STOP;
		if (addr < STEP_FOLD) begin
			cw.op = OP_ROUND;
			cw.seq = SEQ_NEXT;
			case (addr[4:3])
				2'd0: begin
					cw.fsel = FN_F;
					cw.widx = addr[2:0];
					cw.rot = sh_f[addr[1:0]];
				end
				2'd1: begin
					cw.fsel = FN_G;
					cw.widx = ord_g[addr[2:0]];
					cw.rot = sh_g[addr[1:0]];
				end
				default: begin
					cw.fsel = FN_H;
					cw.widx = ord_h[addr[2:0]];
					cw.rot = sh_h[addr[1:0]];
				end
			endcase
		end else if (addr == STEP_FOLD) begin
			cw.op = OP_FOLD;
			cw.seq = SEQ_JLAST;
		end else if (addr == STEP_EMIT) begin
			cw.op = OP_EMIT;
			cw.seq = SEQ_WAIT;
		end
		return cw;
	endfunction

endpackage

FILE: sv/dnh_ucode_seq.sv
module dnh_ucode_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  dnh_pkg::launch_t launch,
	input  logic             out_free,
	output dnh_pkg::ctrl_t   ctrl,
	output logic             busy
);

	logic [dnh_pkg::StepW-1:0] step_q;
	logic busy_q;
	logic last_q;
	dnh_pkg::ctrl_t rom_word;

	assign rom_word = dnh_pkg::ucode_rom(step_q);

	always_comb begin
		ctrl = rom_word;
		if (!busy_q) begin
			ctrl.op = dnh_pkg::OP_NOP;
		end
	end

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= dnh_pkg::STEP_FIRST;
			busy_q <= 1'b0;
			last_q <= 1'b0;
		end else if (!busy_q) begin
			if (launch.go_xform) begin
				step_q <= dnh_pkg::STEP_FIRST;
				busy_q <= 1'b1;
				last_q <= launch.is_last;
			end else if (launch.go_emit) begin
				step_q <= dnh_pkg::STEP_EMIT;
				busy_q <= 1'b1;
				last_q <= 1'b1;
			end
		end else begin
			unique case (rom_word.seq)
				dnh_pkg::SEQ_NEXT: begin
					step_q <= step_q + 5'd1;
				end
				dnh_pkg::SEQ_JLAST: begin
					if (last_q) begin
						step_q <= dnh_pkg::STEP_EMIT;
					end else begin
						busy_q <= 1'b0;
					end
				end
				dnh_pkg::SEQ_WAIT: begin
					if (out_free) begin
						busy_q <= 1'b0;
					end
				end
				default: begin
					busy_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

FILE: sv/dnh_msg_buf.sv
module dnh_msg_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  dnh_pkg::byte_req_t req,
	input  logic [7:0]         version,
	input  logic [2:0]         widx,
	output logic [31:0]        word,
	output logic               load_chain,
	output dnh_pkg::launch_t   launch
);

	logic        in_name_q;
	logic [7:0]  bytes_q;
	logic [31:0] acc_q;
	logic [31:0] blk_q [dnh_pkg::NumBlockWords];

	logic        start;
	logic        empty;
	logic [7:0]  bt;
	logic [4:0]  pos;
	logic [5:0]  pos_p1;
	logic [2:0]  fill_w;
	logic [7:0]  pad_b;
	logic [31:0] pad;
	logic [31:0] ch;
	logic [31:0] acc_a;
	logic [31:0] acc_b;
	logic [31:0] acc_next;
	logic        word_done;
	logic        blk_end;
	logic        run;
	logic [dnh_pkg::NumBlockWords-1:0] we;
	logic [31:0] wd [dnh_pkg::NumBlockWords];

	assign start = ~in_name_q;
	assign empty = start & (req.total_len == 8'd0);
	assign bt = start ? 8'd0 : bytes_q;
	assign pos = bt[4:0];
	assign pos_p1 = {1'b0, pos} + 6'd1;
	assign fill_w = pos_p1[4:2];
	assign pad_b = req.total_len - {bt[7:5], 5'd0};
	assign pad = {4{pad_b}};
	assign ch = (version != dnh_pkg::VER_UNSIGNED && req.name_byte[7]) ?
		{24'hffffff, req.name_byte} : {24'h000000, req.name_byte};
	assign acc_a = (pos == 5'd0) ? pad : (start ? 32'd0 : acc_q);
	// Adding, not or-ing: a sign-extended byte carries into the upper bytes.
	assign acc_b = ch + {acc_a[23:0], 8'h00};
	assign word_done = (pos[1:0] == 2'd3);
	assign acc_next = word_done ? pad : acc_b;
	assign blk_end = (pos == 5'd31);
	assign run = ~empty & (blk_end | req.last_byte);

	assign load_chain = accept & start;
	assign launch.go_xform = accept & run;
	assign launch.go_emit = accept & empty & req.last_byte;
	assign launch.is_last = req.last_byte;

	always_comb begin
		for (int j = 0; j < dnh_pkg::NumBlockWords; j++) begin
			we[j] = 1'b0;
			wd[j] = pad;
			if (accept && !empty) begin
				if (word_done && pos[4:2] == 3'(j)) begin
					we[j] = 1'b1;
					wd[j] = acc_b;
				end
				// A short final block: the partial word, then padding words.
				if (req.last_byte && !blk_end) begin
					if (fill_w == 3'(j)) begin
						we[j] = 1'b1;
						wd[j] = acc_next;
					end else if (fill_w < 3'(j)) begin
						we[j] = 1'b1;
						wd[j] = pad;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < dnh_pkg::NumBlockWords; j++) begin
			if (we[j]) begin
				blk_q[j] <= wd[j];
			end
		end
	end

	assign word = blk_q[widx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_name_q <= 1'b0;
			bytes_q <= 8'd0;
			acc_q <= 32'd0;
		end else if (accept) begin
			if (req.last_byte) begin
				in_name_q <= 1'b0;
				bytes_q <= 8'd0;
				acc_q <= 32'd0;
			end else if (empty) begin
				in_name_q <= 1'b1;
				bytes_q <= 8'd0;
				acc_q <= 32'd0;
			end else begin
				in_name_q <= 1'b1;
				bytes_q <= bt + 8'd1;
				acc_q <= acc_next;
			end
		end
	end

endmodule

FILE: sv/dnh_round_dp.sv
module dnh_round_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic           load_chain,
	input  logic [31:0]    seed [dnh_pkg::NumChain],
	input  dnh_pkg::ctrl_t ctrl,
	input  logic [31:0]    word,
	output logic [31:0]    chain1
);

	logic [31:0] chain_q [dnh_pkg::NumChain];
	logic [31:0] r_q [dnh_pkg::NumChain];
	logic [31:0] chain_d [dnh_pkg::NumChain];
	logic        any_seed;
	logic [31:0] fval;
	logic [31:0] kval;
	logic [31:0] sum;
	logic [63:0] rot_wide;
	logic [31:0] new_a;

	assign any_seed = (seed[0] | seed[1] | seed[2] | seed[3]) != 32'd0;

	always_comb begin
		for (int i = 0; i < dnh_pkg::NumChain; i++) begin
			if (load_chain) begin
				chain_d[i] = any_seed ? seed[i] : dnh_pkg::MD4_START[i];
			end else begin
				chain_d[i] = chain_q[i];
			end
		end
	end

	always_comb begin
		case (ctrl.fsel)
			dnh_pkg::FN_F: begin
				fval = r_q[3] ^ (r_q[1] & (r_q[2] ^ r_q[3]));
				kval = 32'd0;
			end
			dnh_pkg::FN_G: begin
				// The two terms never share a set bit, so the sum is a majority.
				fval = (r_q[1] & r_q[2]) | ((r_q[1] ^ r_q[2]) & r_q[3]);
				kval = dnh_pkg::MD4_K2;
			end
			default: begin
				fval = r_q[1] ^ r_q[2] ^ r_q[3];
				kval = dnh_pkg::MD4_K3;
			end
		endcase
	end

	assign sum = r_q[0] + fval + word + kval;
	assign rot_wide = {32'd0, sum} << ctrl.rot;
	assign new_a = rot_wide[31:0] | rot_wide[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dnh_pkg::NumChain; i++) begin
				chain_q[i] <= dnh_pkg::MD4_START[i];
			end
		end else if (accept) begin
			for (int i = 0; i < dnh_pkg::NumChain; i++) begin
				chain_q[i] <= chain_d[i];
			end
		end else if (ctrl.op == dnh_pkg::OP_FOLD) begin
			for (int i = 0; i < dnh_pkg::NumChain; i++) begin
				chain_q[i] <= chain_q[i] + r_q[i];
			end
		end
	end

	// Working words rotate one place per step; after 24 steps they are home again.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < dnh_pkg::NumChain; i++) begin
				r_q[i] <= chain_d[i];
			end
		end else if (ctrl.op == dnh_pkg::OP_ROUND) begin
			r_q[0] <= r_q[3];
			r_q[1] <= new_a;
			r_q[2] <= r_q[1];
			r_q[3] <= r_q[2];
		end
	end

	assign chain1 = chain_q[1];

endmodule

FILE: sv/dir_name_half_md4_hash.sv
// Name bytes are taken while the round unit is not busy. A byte that
// completes a 32-byte block, and the last byte of a non-empty name, start the 24-round
// transform and a fold step. After a last byte the emit step follows the fold (an empty
// name goes straight to it), waits for a free output register and puts the hash there.
// Reset (arst_n low) clears seeds to zero, version to 1, the chain to the MD4 start
// values and drops any name in progress.
module dir_name_half_md4_hash (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  dnh_pkg::byte_req_t byte_req,
	output logic               hash_valid,
	input  logic               hash_ready,
	output dnh_pkg::hash_rsp_t hash_req,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [31:0] seed_q [dnh_pkg::NumChain];
	logic [7:0]  version_q;
	logic        hash_valid_q;
	dnh_pkg::hash_rsp_t hash_q;

	logic        accept;
	logic        busy;
	logic        out_free;
	logic        load_chain;
	logic [31:0] word;
	logic [31:0] chain1;
	logic [31:0] hash_raw;
	logic        bad_ver;
	logic [2:0]  reg_idx;
	dnh_pkg::ctrl_t   ctrl;
	dnh_pkg::launch_t launch;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dnh_pkg::NumChain; i++) begin
				seed_q[i] <= 32'd0;
			end
			version_q <= dnh_pkg::VER_SIGNED;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				dnh_pkg::REG_SEED0: seed_q[0] <= pwdata;
				dnh_pkg::REG_SEED1: seed_q[1] <= pwdata;
				dnh_pkg::REG_SEED2: seed_q[2] <= pwdata;
				dnh_pkg::REG_SEED3: seed_q[3] <= pwdata;
				dnh_pkg::REG_VERSION: version_q <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			dnh_pkg::REG_SEED0: prdata = seed_q[0];
			dnh_pkg::REG_SEED1: prdata = seed_q[1];
			dnh_pkg::REG_SEED2: prdata = seed_q[2];
			dnh_pkg::REG_SEED3: prdata = seed_q[3];
			dnh_pkg::REG_VERSION: prdata = {24'd0, version_q};
			default: prdata = 32'd0;
		endcase
	end

	assign byte_ready = ~busy;
	assign accept = byte_valid & byte_ready;
	assign out_free = ~hash_valid_q | hash_ready;

	dnh_msg_buf u_msg_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req        (byte_req),
		.version    (version_q),
		.widx       (ctrl.widx),
		.word       (word),
		.load_chain (load_chain),
		.launch     (launch)
	);

	dnh_ucode_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.launch   (launch),
		.out_free (out_free),
		.ctrl     (ctrl),
		.busy     (busy)
	);

	dnh_round_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.load_chain (load_chain),
		.seed       (seed_q),
		.ctrl       (ctrl),
		.word       (word),
		.chain1     (chain1)
	);

	assign bad_ver = (version_q != dnh_pkg::VER_SIGNED) &&
		(version_q != dnh_pkg::VER_UNSIGNED);
	assign hash_raw = {chain1[31:1], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_valid_q <= 1'b0;
		end else if (ctrl.op == dnh_pkg::OP_EMIT && out_free) begin
			hash_valid_q <= 1'b1;
		end else if (hash_ready) begin
			hash_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == dnh_pkg::OP_EMIT && out_free) begin
			if (bad_ver) begin
				hash_q.hash_value <= 32'd0;
				hash_q.status <= dnh_pkg::STATUS_BAD_VERSION;
			end else begin
				hash_q.hash_value <= (hash_raw == dnh_pkg::HASH_SPECIAL) ?
					dnh_pkg::HASH_SUBST : hash_raw;
				hash_q.status <= dnh_pkg::STATUS_OK;
			end
		end
	end

	assign hash_valid = hash_valid_q;
	assign hash_req = hash_q;

	a_hash_even: assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid |-> hash_req.hash_value[0] == 1'b0)
		else $error("hash value has bit 0 set");

	a_bad_ver_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid && hash_req.status == dnh_pkg::STATUS_BAD_VERSION |->
			hash_req.hash_value == 32'd0)
		else $error("rejected version produced a nonzero hash");

	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && byte_req.last_byte |=> !byte_ready)
		else $error("last byte did not start the hash sequence");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid && !hash_ready |=> $stable(hash_req))
		else $error("pending hash overwritten");

endmodule
